// ===== rtl/isl_pkg.sv =====
// Package for the indexed LIFO stack: operation and status codes, default depth,
// and the command bundle from the controller to the datapath.
// No dependencies.
package isl_pkg;

  localparam int DEPTH_DEF = 128;

  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 8;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEP   = 3'd3;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

// ===== rtl/isl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/isl_ctrl.sv =====
// Controller for the indexed LIFO stack: sequences accept, execute and respond,
// and owns the output valid flag. Depends on isl_pkg.
module isl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output isl_pkg::cmd_t cmd
);

  import isl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("Accepted transaction did not start execution.");

  a_exec_to_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_RESP))
    else $error("Execute state did not move to respond.");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_free) |=> (out_valid && state == S_IDLE))
    else $error("Result was not presented after respond.");
`endif

endmodule

// ===== rtl/isl_dp.sv =====
// Datapath for the indexed LIFO stack: item register, element count, address
// and status logic, element RAM and output register. Depends on isl_pkg, isl_ram.
module isl_dp #(
  parameter int DEPTH = isl_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  isl_pkg::cmd_t                   cmd,
  input  logic [isl_pkg::OP_W-1:0]        operation,
  input  logic [isl_pkg::POS_W-1:0]       position,
  input  logic signed [isl_pkg::WORD_W-1:0] value,
  output logic [isl_pkg::STATUS_W-1:0]    status,
  output logic signed [isl_pkg::WORD_W-1:0] data,
  output logic [isl_pkg::FILL_W-1:0]      fill_count
);

  import isl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [OP_W-1:0]     op_q;
  logic [POS_W-1:0]    pos_q;
  logic [WORD_W-1:0]   val_q;
  logic [CW-1:0]       count, count_next;
  logic [STATUS_W-1:0] status_q, status_n;
  logic                rd_q, rd_n;

  logic [XW-1:0]     pos_x, cnt_x, idx_x, top_x;
  logic              found, full, empty;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_rdata;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(count);
  assign idx_x = cnt_x - pos_x;
  assign top_x = cnt_x - XW'(1);
  assign found = (pos_x != '0) && (pos_x <= cnt_x);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    count_next = count;
    status_n   = ST_OK;
    rd_n       = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = AW'(count);
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          status_n = ST_OVERFLOW;
        end else begin
          ram_we     = cmd.exec;
          ram_addr   = AW'(count);
          count_next = count + CW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_n = ST_EMPTY;
        end else begin
          ram_re     = cmd.exec;
          ram_addr   = AW'(top_x);
          rd_n       = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_n = ST_EMPTY;
        end else begin
          ram_re   = cmd.exec;
          ram_addr = AW'(top_x);
          rd_n     = 1'b1;
        end
      end
      OP_PEEP: begin
        if (found) begin
          ram_re   = cmd.exec;
          ram_addr = AW'(idx_x);
          rd_n     = 1'b1;
        end else begin
          status_n = ST_NOT_FOUND;
        end
      end
      OP_CHANGE: begin
        if (found) begin
          ram_we   = cmd.exec;
          ram_addr = AW'(idx_x);
        end else begin
          status_n = ST_NOT_FOUND;
        end
      end
      default: begin
        status_n = ST_OK;
      end
    endcase
  end

  isl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(val_q),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= operation;
      pos_q <= position;
      val_q <= value;
    end
    if (cmd.exec) begin
      status_q <= status_n;
      rd_q     <= rd_n;
    end
    if (cmd.load_out) begin
      status     <= status_q;
      data       <= rd_q ? ram_rdata : '0;
      fill_count <= FILL_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("Element count exceeds the depth.");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (XW'(ram_addr) <= cnt_x))
    else $error("RAM write above the top of the stack.");
`endif

endmodule

// ===== rtl/indexed_lifo_stack.sv =====
// Indexed LIFO stack: push, pop, peek, peep and change on signed 32-bit words.
// After the accepting clock edge, the controller's execute state performs the RAM access,
// then its respond state loads the registered read data into the output register.
// A new transaction is accepted only in the idle state, after respond; a result held by
// m_tready keeps the current transaction waiting in respond.
// Synchronous active-high reset empties the stack; RAM contents are not cleared.
module indexed_lifo_stack #(
  parameter int DEPTH = isl_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // Fields from bit 0: operation[2:0], position[10:3], value[42:11], upper bits unused.
  input  logic [isl_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // Fields from bit 0: status[1:0], data[33:2], fill_count[41:34], zero fill.
  output logic [isl_pkg::OUT_W-1:0] m_tdata
);

  import isl_pkg::*;

  cmd_t                      cmd;
  logic [STATUS_W-1:0]       status;
  logic signed [WORD_W-1:0]  data;
  logic [FILL_W-1:0]         fill_count;

  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd)
  );

  isl_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (s_tdata[2:0]),
    .position  (s_tdata[10:3]),
    .value     (s_tdata[42:11]),
    .status    (status),
    .data      (data),
    .fill_count(fill_count)
  );

  assign m_tdata = {6'd0, fill_count, data, status};

endmodule
